@@ rtl/set_assoc_cache_lru_tags_core_assert.svh @@
// assertion macros used by the checker file of the lru tag store
// no dependencies
`ifndef SET_ASSOC_CACHE_LRU_TAGS_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_CORE_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru tag store check failed");

// implication in the next cycle
`define SACL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru tag store check failed");

// delayed implication
`define SACL_ASSERT_AFTER2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("lru tag store check failed");

`endif

@@ rtl/sacl_pkg.sv @@
// constants, types and state codes of the lru tag store
// no dependencies
package sacl_pkg;

  localparam int ADDR_W       = 32;
  localparam int CNT_W        = 32;
  localparam int TAG_W        = 20;
  localparam int WAY_OUT_W    = 3;
  localparam int SET_OUT_W    = 6;
  localparam int NUM_SETS     = 64;
  localparam int BLOCK_BYTES  = 64;
  localparam int SET_W        = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int OFS_W        = $clog2(BLOCK_BYTES);
  localparam int DEF_NUM_WAYS = 8;
  localparam int DEF_AGE_BITS = 8;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_t;

  typedef struct packed {
    logic hit;
    logic filled;
    logic replaced;
  } lookup_flags_t;

endpackage

@@ rtl/sacl_ram.sv @@
// set memory of the lru tag store: one row of ways per set, registered read
// depends on sacl_pkg
module sacl_ram #(
  parameter int ROW_W = 29
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [sacl_pkg::SET_W-1:0] rd_set,
  output logic [ROW_W-1:0]           rd_row,
  output logic                       rd_ok,
  input  logic                       wr_en,
  input  logic [sacl_pkg::SET_W-1:0] wr_set,
  input  logic [ROW_W-1:0]           wr_row
);
  import sacl_pkg::*;

  logic [ROW_W-1:0]    mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rd_row <= mem[rd_set];
    end
  end

  // rows never written since reset read with rd_ok low
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[wr_set] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= row_vld[rd_set];
      end
    end
  end

endmodule

@@ rtl/sacl_lookup.sv @@
// tag compare, victim choice and age update over one set row
// depends on sacl_pkg
module sacl_lookup #(
  parameter int NUM_WAYS = 8,
  parameter int AGE_BITS = 8,
  parameter int WAY_W    = 3,
  parameter int ENTRY_W  = 29,
  parameter int ROW_W    = 232
) (
  input  logic [sacl_pkg::TAG_W-1:0] tag,
  input  logic                       row_ok,
  input  logic [ROW_W-1:0]           row,
  output logic [WAY_W-1:0]           way,
  output sacl_pkg::lookup_flags_t    flags,
  output logic [ROW_W-1:0]           row_next
);
  import sacl_pkg::*;

  logic [NUM_WAYS-1:0] vld;
  logic [NUM_WAYS-1:0] match;
  logic [TAG_W-1:0]    tags [NUM_WAYS];
  logic [AGE_BITS-1:0] ages [NUM_WAYS];
  logic                hit_found;
  logic                inv_found;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    best_way;
  logic [AGE_BITS-1:0] best_age;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      vld[w]   = row_ok & row[w*ENTRY_W + ENTRY_W - 1];
      tags[w]  = row_ok ? row[w*ENTRY_W + AGE_BITS +: TAG_W] : '0;
      ages[w]  = row_ok ? row[w*ENTRY_W +: AGE_BITS] : '0;
      match[w] = vld[w] && (tags[w] == tag);
    end
  end

  // lowest index wins for hit and free way
  always_comb begin
    hit_found = 1'b0;
    inv_found = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_found = 1'b1;
        hit_way   = WAY_W'(w);
      end
      if (!vld[w]) begin
        inv_found = 1'b1;
        inv_way   = WAY_W'(w);
      end
    end
  end

  // oldest way, lowest index on ties
  always_comb begin
    best_age = ages[0];
    best_way = '0;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (ages[w] > best_age) begin
        best_age = ages[w];
        best_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    flags.hit      = hit_found;
    flags.filled   = 1'b0;
    flags.replaced = 1'b0;
    if (hit_found) begin
      way = hit_way;
    end else if (inv_found) begin
      way          = inv_way;
      flags.filled = 1'b1;
    end else begin
      way            = best_way;
      flags.replaced = 1'b1;
    end
  end

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (WAY_W'(w) == way) begin
        row_next[w*ENTRY_W +: ENTRY_W] = {1'b1, tag, {AGE_BITS{1'b0}}};
      end else if (vld[w]) begin
        row_next[w*ENTRY_W +: ENTRY_W] = {1'b1, tags[w],
          (ages[w] == {AGE_BITS{1'b1}}) ? ages[w] : ages[w] + AGE_BITS'(1)};
      end else begin
        row_next[w*ENTRY_W +: ENTRY_W] = {1'b0, tags[w], ages[w]};
      end
    end
  end

endmodule

@@ rtl/set_assoc_cache_lru_tags_core.sv @@
// top level of the lru tag store: control, counters and result registers
// depends on sacl_pkg, sacl_ram, sacl_lookup
//
// usage
//   an access is a transaction on start/address: it is taken at a rising edge
//   where start is high and busy is low. the address is split into a 6-bit
//   block offset, a 6-bit set and a 20-bit tag.
//   the result is shown for exactly one cycle with done high: hit, way,
//   set_index, tag_value, filled_invalid, replaced_valid and the running
//   hit_count and miss_count, which include this access.
// timing
//   done rises at the edge that ends the lookup state, which follows the
//   accepting edge. busy is high for the cycle after acceptance, so a new
//   access is not taken until the current one has been looked up. the set
//   memory first reads the set row, then the lookup compares and writes the
//   updated row back. busy also keeps a following access off a row whose
//   write back is still pending.
// reset
//   rst clears the control state, the counters and the per-set row valid
//   flags, so every set reads as empty at once; no clearing pass is needed.
// the receiver takes every result in its done cycle and cannot stall.
module set_assoc_cache_lru_tags_core #(
  parameter int NUM_WAYS = sacl_pkg::DEF_NUM_WAYS,
  parameter int AGE_BITS = sacl_pkg::DEF_AGE_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [sacl_pkg::ADDR_W-1:0]    address,
  output logic                           done,
  output logic                           hit,
  output logic [sacl_pkg::WAY_OUT_W-1:0] way,
  output logic [sacl_pkg::SET_OUT_W-1:0] set_index,
  output logic [sacl_pkg::TAG_W-1:0]     tag_value,
  output logic                           filled_invalid,
  output logic                           replaced_valid,
  output logic [sacl_pkg::CNT_W-1:0]     hit_count,
  output logic [sacl_pkg::CNT_W-1:0]     miss_count
);
  import sacl_pkg::*;

  localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ENTRY_W = 1 + TAG_W + AGE_BITS;
  localparam int ROW_W   = NUM_WAYS * ENTRY_W;

  ctrl_state_t      state;
  ctrl_state_t      state_next;
  logic             accept;
  logic [ADDR_W-1:0] addr_q;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;
  logic [ROW_W-1:0] rd_row;
  logic             rd_ok;
  logic [ROW_W-1:0] row_next;
  logic [WAY_W-1:0] lk_way;
  lookup_flags_t    lk_flags;
  logic             do_update;

  assign accept    = start && !busy;
  assign do_update = (state == ST_LOOKUP);
  assign cur_set   = addr_q[OFS_W +: SET_W];
  assign cur_tag   = TAG_W'(addr_q >> (OFS_W + SET_W));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        busy       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q <= address;
    end
  end

  sacl_ram #(
    .ROW_W(ROW_W)
  ) u_ram (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_set (address[OFS_W +: SET_W]),
    .rd_row (rd_row),
    .rd_ok  (rd_ok),
    .wr_en  (do_update),
    .wr_set (cur_set),
    .wr_row (row_next)
  );

  sacl_lookup #(
    .NUM_WAYS(NUM_WAYS),
    .AGE_BITS(AGE_BITS),
    .WAY_W   (WAY_W),
    .ENTRY_W (ENTRY_W),
    .ROW_W   (ROW_W)
  ) u_lookup (
    .tag      (cur_tag),
    .row_ok   (rd_ok),
    .row      (rd_row),
    .way      (lk_way),
    .flags    (lk_flags),
    .row_next (row_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      hit_count  <= '0;
      miss_count <= '0;
    end else begin
      done <= do_update;
      if (do_update) begin
        if (lk_flags.hit) begin
          hit_count <= hit_count + CNT_W'(1);
        end else begin
          miss_count <= miss_count + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      hit            <= lk_flags.hit;
      way            <= WAY_OUT_W'(lk_way);
      set_index      <= SET_OUT_W'(cur_set);
      tag_value      <= cur_tag;
      filled_invalid <= lk_flags.filled;
      replaced_valid <= lk_flags.replaced;
    end
  end

endmodule

@@ rtl/sacl_checker.sv @@
// port-level checks of the lru tag store, bound to the top level
// depends on set_assoc_cache_lru_tags_core_assert.svh and set_assoc_cache_lru_tags_core
`include "set_assoc_cache_lru_tags_core_assert.svh"

module sacl_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic hit,
  input logic filled_invalid,
  input logic replaced_valid
);

  `SACL_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
  `SACL_ASSERT_AFTER2(a_done_after_accept, start && !busy, done)
  `SACL_ASSERT_NOW(a_hit_no_fill, done && hit, !filled_invalid && !replaced_valid)
  `SACL_ASSERT_NOW(a_miss_one_kind, done && !hit, filled_invalid ^ replaced_valid)

endmodule

bind set_assoc_cache_lru_tags_core sacl_checker u_checker (.*);

@@ dv/set_assoc_cache_lru_tags_core_tb.sv @@
// testbench for the lru tag store: sends address transactions in bursts and
// checks every result against a cycle-free model of the tag, valid and age rows
// depends on sacl_pkg and set_assoc_cache_lru_tags_core
`timescale 1ns / 1ps

module set_assoc_cache_lru_tags_core_tb;
  import sacl_pkg::*;

  localparam int WAYS = DEF_NUM_WAYS;
  localparam logic [DEF_AGE_BITS-1:0] AGE_MAX = {DEF_AGE_BITS{1'b1}};

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way;
    logic [SET_OUT_W-1:0] set_index;
    logic [TAG_W-1:0]     tag_value;
    logic                 filled_invalid;
    logic                 replaced_valid;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
  } access_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [ADDR_W-1:0]    address = '0;
  logic                 busy;
  logic                 done;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way;
  logic [SET_OUT_W-1:0] set_index;
  logic [TAG_W-1:0]     tag_value;
  logic                 filled_invalid;
  logic                 replaced_valid;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     miss_count;

  // model of the tag store
  logic                    row_valid [NUM_SETS][WAYS];
  logic [TAG_W-1:0]        row_tag   [NUM_SETS][WAYS];
  logic [DEF_AGE_BITS-1:0] row_age   [NUM_SETS][WAYS];
  logic [CNT_W-1:0]        model_hits = '0;
  logic [CNT_W-1:0]        model_misses = '0;

  access_result_t pending_results[$];
  access_result_t oldest;
  int             mismatches = 0;
  int             burst_left = 0;

  set_assoc_cache_lru_tags_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .address(address),
    .done(done),
    .hit(hit),
    .way(way),
    .set_index(set_index),
    .tag_value(tag_value),
    .filled_invalid(filled_invalid),
    .replaced_valid(replaced_valid),
    .hit_count(hit_count),
    .miss_count(miss_count)
  );

  always #6 clk = ~clk;

  function automatic logic [ADDR_W-1:0] make_address(input logic [SET_W-1:0] s,
                                                     input logic [TAG_W-1:0] t);
    logic [OFS_W-1:0] ofs;
    ofs = OFS_W'($urandom_range(BLOCK_BYTES - 1));
    return {t, s, ofs};
  endfunction

  task automatic lookup_and_update(input logic [ADDR_W-1:0] a);
    access_result_t r;
    logic [SET_W-1:0] s;
    logic [DEF_AGE_BITS-1:0] oldest_age;
    int i;
    s = a[OFS_W +: SET_W];
    r = '0;
    r.set_index = s;
    r.tag_value = a[ADDR_W-1 -: TAG_W];
    for (i = 0; i < WAYS; i++) begin
      if (!r.hit && row_valid[s][i] && row_tag[s][i] == r.tag_value) begin
        r.hit = 1'b1;
        r.way = WAY_OUT_W'(i);
      end
    end
    if (r.hit) begin
      model_hits = model_hits + CNT_W'(1);
    end else begin
      model_misses = model_misses + CNT_W'(1);
      for (i = 0; i < WAYS; i++) begin
        if (!r.filled_invalid && !row_valid[s][i]) begin
          r.filled_invalid = 1'b1;
          r.way = WAY_OUT_W'(i);
        end
      end
      if (!r.filled_invalid) begin
        r.replaced_valid = 1'b1;
        r.way = '0;
        oldest_age = row_age[s][0];
        for (i = 1; i < WAYS; i++) begin
          if (row_age[s][i] > oldest_age) begin
            oldest_age = row_age[s][i];
            r.way = WAY_OUT_W'(i);
          end
        end
      end
      row_valid[s][r.way] = 1'b1;
      row_tag[s][r.way] = r.tag_value;
      row_age[s][r.way] = '0;
    end
    for (i = 0; i < WAYS; i++) begin
      if (row_valid[s][i]) begin
        if (i == r.way) row_age[s][i] = '0;
        else if (row_age[s][i] != AGE_MAX)
          row_age[s][i] = row_age[s][i] + DEF_AGE_BITS'(1);
      end
    end
    r.hit_count = model_hits;
    r.miss_count = model_misses;
    pending_results.push_back(r);
  endtask

  // bursts of back-to-back transactions, with idle gaps between most of them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_access(input logic [ADDR_W-1:0] a);
    pace_sender();
    start <= 1'b1;
    address <= a;
    do @(posedge clk); while (busy);
    lookup_and_update(a);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("hit", 32'(oldest.hit), 32'(hit));
        check_field("way", 32'(oldest.way), 32'(way));
        check_field("set_index", 32'(oldest.set_index), 32'(set_index));
        check_field("tag_value", 32'(oldest.tag_value), 32'(tag_value));
        check_field("filled_invalid", 32'(oldest.filled_invalid), 32'(filled_invalid));
        check_field("replaced_valid", 32'(oldest.replaced_valid), 32'(replaced_valid));
        check_field("hit_count", oldest.hit_count, hit_count);
        check_field("miss_count", oldest.miss_count, miss_count);
      end
    end
  end

  task automatic test_address_extremes();
    send_access(32'h0000_0000);
    send_access(32'h0000_003F);
    send_access(32'hFFFF_FFFF);
    send_access(32'hFFFF_FFC0);
    send_access(32'h0000_0FC0);
    send_access(32'hFFFF_F03F);
  endtask

  task automatic test_fill_and_evict();
    int i;
    for (i = 1; i <= WAYS; i++) send_access(make_address(6'd10, TAG_W'(i)));
    send_access(make_address(6'd10, 20'd1));
    send_access(make_address(6'd10, 20'd9));
    send_access(make_address(6'd10, 20'd2));
    send_access(make_address(6'd10, 20'd5));
  endtask

  // two ways left untouched saturate together, then tie on eviction
  task automatic test_age_saturation();
    logic [TAG_W-1:0] tags [WAYS];
    int i;
    for (i = 0; i < WAYS; i++) begin
      tags[i] = {8'($urandom_range(255)), 12'h000} | TAG_W'(i);
      send_access(make_address(6'd33, tags[i]));
    end
    for (i = 0; i < 300; i++) send_access(make_address(6'd33, tags[$urandom_range(2, WAYS - 1)]));
    send_access(make_address(6'd33, 20'hABCDE));
    send_access(make_address(6'd33, 20'h12345));
    send_access(make_address(6'd33, tags[3]));
  endtask

  task automatic test_random_traffic(input int count);
    logic [SET_W-1:0] hot_sets [4];
    logic [TAG_W-1:0] tag_pool [12];
    int i;
    int j;
    for (i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        for (j = 0; j < 4; j++) hot_sets[j] = SET_W'($urandom_range(NUM_SETS - 1));
        for (j = 0; j < 12; j++) tag_pool[j] = TAG_W'($urandom);
      end
      if ($urandom_range(99) < 75)
        send_access(make_address(hot_sets[$urandom_range(3)],
                                 tag_pool[$urandom_range(8 + i % 4)]));
      else
        send_access($urandom);
    end
  endtask

  initial begin
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        row_valid[s][w] = 1'b0;
        row_tag[s][w] = '0;
        row_age[s][w] = '0;
      end
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_address_extremes();
    test_fill_and_evict();
    test_age_saturation();
    test_random_traffic(1600);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("set_assoc_cache_lru_tags_core test passed");
    end else begin
      $display("set_assoc_cache_lru_tags_core test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("set_assoc_cache_lru_tags_core test failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sacl_pkg.sv
rtl/sacl_ram.sv
rtl/sacl_lookup.sv
rtl/set_assoc_cache_lru_tags_core.sv
rtl/sacl_checker.sv
dv/set_assoc_cache_lru_tags_core_tb.sv
